FILE: sv/tfp_pkg.sv
// Shared constants for the tile file name parser: character codes, extension table,
// file type codes and configuration register indexes.
// No dependencies.
package tfp_pkg;

	localparam int COORD_BITS_DEF = 32;

	// Configuration port
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS = 8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DIGITS = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SKIP_CHARS = 8'd1;
	localparam logic [3:0] MIN_DIGITS_RESET = 4'd1;
	localparam logic [7:0] SKIP_CHARS_RESET = 8'd0;
	localparam logic [3:0] MIN_DIGITS_LO = 4'd1;
	localparam logic [3:0] MIN_DIGITS_HI = 4'd10;

	// Character codes
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_DOT = 8'h2e;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// Lod range
	localparam logic [7:0] LOD_MAX = 8'd255;

	// Extensions, in file type order
	localparam int EXT_COUNT = 3;
	localparam logic [2:0] EXT_POS_MAX = 3'd4;
	localparam logic [2:0] EXT_ALL = 3'b111;
	localparam logic [7:0] EXT_TEXT [EXT_COUNT][4] = '{
		'{8'h6d, 8'h65, 8'h74, 8'h61},  // meta
		'{8'h62, 8'h69, 8'h6e, 8'h00},  // bin
		'{8'h6a, 8'h70, 8'h67, 8'h00}   // jpg
	};
	localparam logic [2:0] EXT_LEN [EXT_COUNT] = '{3'd4, 3'd3, 3'd3};

	typedef enum logic [1:0] {
		FT_META = 2'd0,
		FT_BIN  = 2'd1,
		FT_JPG  = 2'd2
	} file_type_t;

endpackage

FILE: sv/tile_filename_parser_top.sv
// Tile file name parser, top level: input stage, per-name parse state, result register.
// Depends on tfp_pkg (constants, extension table, file type codes).
// Characters are checked one per cycle, unless the input stalls, against the pattern lod-x-y.ext.

// The block takes one character beat per clock cycle while the input does not stall, with
// no gaps between names. A character is held in the input stage, where a single pass of
// logic (a multiply-by-ten accumulate done as shift-add, a bound compare, and the
// separator and extension checks) updates the parse state. Each beat flagged last_char
// produces exactly one result beat, loaded into the result register as the beat leaves the
// input stage; other characters produce nothing. The result register parts the two sides,
// so a new character is taken while a finished result waits; only a second last_char
// finding the result register still full stalls the input. Numbers may carry one leading
// minus, need min_digits digits (one fewer after a minus, never fewer than one), take a
// leading zero only at exactly that width and reject minus zero. lod must lie in 0..255,
// x and y in the signed COORD_BITS range. The extension must be meta, bin or jpg; a zero
// byte ends the name and later characters are ignored up to last_char. On failure all
// result fields read zero. Write min_digits (index 0) and skip_chars (index 1) only while
// no name is in flight; the config port is always ready.
module tile_filename_parser_top #(
	parameter int COORD_BITS = tfp_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tfp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tfp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// character channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        char_code,
	input  logic                              last_char,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              parse_ok,
	output logic [7:0]                        tile_lod,
	output logic signed [COORD_BITS-1:0]      tile_x,
	output logic signed [COORD_BITS-1:0]      tile_y,
	output logic [1:0]                        file_type
);

	// Magnitude register holds up to 2^(COORD_BITS-1); the product needs four more bits.
	localparam int AW = COORD_BITS + 1;
	localparam int PW = AW + 4;
	localparam logic [AW-1:0] LIM_NEG = AW'(1) << (COORD_BITS - 1);
	localparam logic [AW-1:0] LIM_POS = (AW'(1) << (COORD_BITS - 1)) - AW'(1);
	localparam logic [AW-1:0] LIM_LOD = AW'(tfp_pkg::LOD_MAX);

	typedef enum logic [1:0] {
		PH_LOD,
		PH_X,
		PH_Y,
		PH_EXT
	} phase_t;

	// True when a live candidate has exactly the length consumed so far.
	function automatic logic ext_hit(input logic [2:0] cand, input logic [2:0] pos);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < tfp_pkg::EXT_COUNT; k++) begin
			if (cand[k] && (tfp_pkg::EXT_LEN[k] == pos)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// Configuration registers
	logic [3:0] min_digits_q;
	logic [7:0] skip_chars_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       advance;

	// Per-name parse state
	phase_t          phase_q, n_phase;
	logic            neg_q, n_neg;
	logic            lz_q, n_lz;
	logic [3:0]      dc_q, n_dc;
	logic [AW-1:0]   acc_q, n_acc;
	logic [7:0]      lod_q, n_lod;
	logic [COORD_BITS-1:0] col_q, n_col;
	logic [COORD_BITS-1:0] row_q, n_row;
	logic [2:0]      epos_q, n_epos;
	logic [2:0]      ecand_q, n_ecand;
	logic            failed_q, n_failed;
	logic            ended_q, n_ended;
	logic [7:0]      skip_q, n_skip;

	// Result register
	logic                  out_valid_q;
	logic                  ok_q;
	logic [7:0]            lod_out_q;
	logic [COORD_BITS-1:0] x_out_q;
	logic [COORD_BITS-1:0] y_out_q;
	logic [1:0]            type_out_q;

	// Step logic
	logic [3:0]      m_clamp;
	logic [3:0]      eff_min;
	logic            is_digit;
	logic [7:0]      digit_diff;
	logic [3:0]      digit;
	logic [3:0]      dc_inc;
	logic            lz_new;
	logic [AW-1:0]   lim;
	logic [PW-1:0]   prod;
	logic [7:0]      sep_char;
	logic [AW-1:0]   signed_val;
	logic [2:0]      ext_keep;
	logic            end_bad_now;
	logic            end_bad_fin;
	logic            fin_fail;
	logic [1:0]      fin_type;

	assign cfg_ready = 1'b1;

	// Take a new beat when the stage is empty or drains this cycle.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_digits_q <= tfp_pkg::MIN_DIGITS_RESET;
			skip_chars_q <= tfp_pkg::SKIP_CHARS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tfp_pkg::REG_MIN_DIGITS) begin
				min_digits_q <= cfg_data[3:0];
			end else if (cfg_index == tfp_pkg::REG_SKIP_CHARS) begin
				skip_chars_q <= cfg_data[7:0];
			end
		end
	end

	// Input stage: hold the beat until the parse logic consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// Field-level helpers
	always_comb begin
		if (min_digits_q < tfp_pkg::MIN_DIGITS_LO) begin
			m_clamp = tfp_pkg::MIN_DIGITS_LO;
		end else if (min_digits_q > tfp_pkg::MIN_DIGITS_HI) begin
			m_clamp = tfp_pkg::MIN_DIGITS_HI;
		end else begin
			m_clamp = min_digits_q;
		end
		// A minus sign counts toward the width, down to one digit.
		if (neg_q && (m_clamp > tfp_pkg::MIN_DIGITS_LO)) begin
			eff_min = m_clamp - 4'd1;
		end else begin
			eff_min = m_clamp;
		end
	end

	assign is_digit   = (char_s1 >= tfp_pkg::CHAR_ZERO) && (char_s1 <= tfp_pkg::CHAR_NINE);
	assign digit_diff = char_s1 - tfp_pkg::CHAR_ZERO;
	assign digit      = digit_diff[3:0];
	assign dc_inc     = (dc_q == 4'hf) ? dc_q : dc_q + 4'd1;
	assign lz_new     = (dc_q == 4'd0) ? (digit == 4'd0) : lz_q;
	assign sep_char   = (phase_q == PH_Y) ? tfp_pkg::CHAR_DOT : tfp_pkg::CHAR_MINUS;
	assign signed_val = neg_q ? (AW'(0) - acc_q) : acc_q;

	always_comb begin
		if (phase_q == PH_LOD) begin
			lim = neg_q ? AW'(0) : LIM_LOD;
		end else begin
			lim = neg_q ? LIM_NEG : LIM_POS;
		end
	end

	// acc*10 + digit as shift-add; exceeding the bound is the overflow test.
	assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {(PW - 4)'(0), digit};

	always_comb begin
		for (int k = 0; k < tfp_pkg::EXT_COUNT; k++) begin
			ext_keep[k] = (epos_q < tfp_pkg::EXT_LEN[k]) &&
				(tfp_pkg::EXT_TEXT[k][epos_q[1:0]] == char_s1);
		end
	end

	assign end_bad_now = (phase_q != PH_EXT) || !ext_hit(ecand_q, epos_q);

	// One character step
	always_comb begin
		n_phase  = phase_q;
		n_neg    = neg_q;
		n_lz     = lz_q;
		n_dc     = dc_q;
		n_acc    = acc_q;
		n_lod    = lod_q;
		n_col    = col_q;
		n_row    = row_q;
		n_epos   = epos_q;
		n_ecand  = ecand_q;
		n_failed = failed_q;
		n_ended  = ended_q;
		n_skip   = skip_q;
		if (skip_q < skip_chars_q) begin
			// Still inside the skipped prefix; a name ending here fails.
			n_skip = skip_q + 8'd1;
			if (last_s1) begin
				n_failed = 1'b1;
			end
		end else if (!ended_q && !failed_q) begin
			if (char_s1 == tfp_pkg::CHAR_NUL) begin
				n_ended = 1'b1;
				if (end_bad_now) begin
					n_failed = 1'b1;
				end
			end else if (phase_q != PH_EXT) begin
				if (is_digit) begin
					n_lz = lz_new;
					n_dc = dc_inc;
					if (lz_new && (dc_inc > eff_min)) begin
						n_failed = 1'b1;
					end else if (prod > {4'b0000, lim}) begin
						n_failed = 1'b1;
					end else begin
						n_acc = prod[AW-1:0];
					end
				end else if ((char_s1 == tfp_pkg::CHAR_MINUS) && (dc_q == 4'd0) && !neg_q) begin
					n_neg = 1'b1;
				end else if ((dc_q < eff_min) || (neg_q && (acc_q == AW'(0))) ||
						(char_s1 != sep_char)) begin
					n_failed = 1'b1;
				end else begin
					// Separator: store the field and open the next one.
					case (phase_q)
						PH_LOD: begin
							n_lod   = signed_val[7:0];
							n_phase = PH_X;
						end
						PH_X: begin
							n_col   = signed_val[COORD_BITS-1:0];
							n_phase = PH_Y;
						end
						default: begin
							n_row   = signed_val[COORD_BITS-1:0];
							n_phase = PH_EXT;
							n_epos  = 3'd0;
							n_ecand = tfp_pkg::EXT_ALL;
						end
					endcase
					n_neg = 1'b0;
					n_lz  = 1'b0;
					n_dc  = 4'd0;
					n_acc = AW'(0);
				end
			end else begin
				if (epos_q >= tfp_pkg::EXT_POS_MAX) begin
					n_failed = 1'b1;
				end else begin
					n_ecand = ecand_q & ext_keep;
					n_epos  = epos_q + 3'd1;
					if ((ecand_q & ext_keep) == 3'b000) begin
						n_failed = 1'b1;
					end
				end
			end
		end
	end

	// End of name on last_char when no zero byte came first.
	assign end_bad_fin = (n_phase != PH_EXT) || !ext_hit(n_ecand, n_epos);
	assign fin_fail    = n_failed || (!n_ended && end_bad_fin);

	always_comb begin
		fin_type = tfp_pkg::FT_META;
		for (int k = tfp_pkg::EXT_COUNT - 1; k >= 0; k--) begin
			if (n_ecand[k] && (tfp_pkg::EXT_LEN[k] == n_epos)) begin
				fin_type = 2'(k);
			end
		end
	end

	// Parse state: advance on each consumed beat, drop back to idle after last_char.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LOD;
			neg_q    <= 1'b0;
			lz_q     <= 1'b0;
			dc_q     <= 4'd0;
			acc_q    <= AW'(0);
			lod_q    <= 8'd0;
			col_q    <= '0;
			row_q    <= '0;
			epos_q   <= 3'd0;
			ecand_q  <= tfp_pkg::EXT_ALL;
			failed_q <= 1'b0;
			ended_q  <= 1'b0;
			skip_q   <= 8'd0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q  <= PH_LOD;
				neg_q    <= 1'b0;
				lz_q     <= 1'b0;
				dc_q     <= 4'd0;
				acc_q    <= AW'(0);
				lod_q    <= 8'd0;
				col_q    <= '0;
				row_q    <= '0;
				epos_q   <= 3'd0;
				ecand_q  <= tfp_pkg::EXT_ALL;
				failed_q <= 1'b0;
				ended_q  <= 1'b0;
				skip_q   <= 8'd0;
			end else begin
				phase_q  <= n_phase;
				neg_q    <= n_neg;
				lz_q     <= n_lz;
				dc_q     <= n_dc;
				acc_q    <= n_acc;
				lod_q    <= n_lod;
				col_q    <= n_col;
				row_q    <= n_row;
				epos_q   <= n_epos;
				ecand_q  <= n_ecand;
				failed_q <= n_failed;
				ended_q  <= n_ended;
				skip_q   <= n_skip;
			end
		end
	end

	// Result register: load on last_char, hold until the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			ok_q       <= !fin_fail;
			lod_out_q  <= fin_fail ? 8'd0 : n_lod;
			x_out_q    <= fin_fail ? '0 : n_col;
			y_out_q    <= fin_fail ? '0 : n_row;
			type_out_q <= fin_fail ? tfp_pkg::FT_META : fin_type;
		end
	end

	assign out_valid = out_valid_q;
	assign parse_ok  = ok_q;
	assign tile_lod  = lod_out_q;
	assign tile_x    = x_out_q;
	assign tile_y    = y_out_q;
	assign file_type = type_out_q;

`ifndef SYNTHESIS
	// A failed name reports all fields as zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parse_ok |-> (tile_lod == 8'd0) && (tile_x == '0) && (tile_y == '0) &&
			(file_type == tfp_pkg::FT_META))
		else $error("failed result carries nonzero fields");

	// Extension tracking stays at its idle value outside the extension phase.
	a_ext_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_EXT |-> (ecand_q == tfp_pkg::EXT_ALL) && (epos_q == 3'd0))
		else $error("extension state moved outside extension phase");

	// No digits taken means an empty accumulator and no leading zero.
	a_field_empty: assert property (@(posedge clk) disable iff (!arst_n)
		dc_q == 4'd0 |-> (acc_q == AW'(0)) && !lz_q)
		else $error("field state without digits");

	// A beat that cannot advance stays in the input stage untouched.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("input stage lost a stalled beat");

	// A finished name always lands in the result register.
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid)
		else $error("last character produced no result");
`endif

endmodule
